// ===== design/swe_pkg.sv =====
`default_nettype none
package swe_pkg;

  localparam int unsigned MAX_VERTICES_DEF   = 1024;
  localparam int unsigned MAX_COMPONENTS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EVAL_MODE      = 1'b0,
    CFG_ELEMENT_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_LOAD        = 2'd0,
    CMD_TERM        = 2'd1,
    CMD_TERM_FINISH = 2'd2,
    CMD_FINISH      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TERM,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cmd_e               command;
    logic [9:0]         vertex_index;
    logic [3:0]         component;
    logic signed [31:0] control_value;
    logic signed [31:0] weight_first;
    logic signed [31:0] weight_second;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_component;
    logic signed [31:0] sum_first;
    logic signed [31:0] sum_second;
    logic               saturated;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic       sel;
    logic [3:0] comp;
  } mac_tag_t;

  typedef struct packed {
    logic [31:0] q;
    logic        sat;
  } rnd_t;

  function automatic rnd_t round_q(input logic [63:0] acc);
    logic [40:0] t;
    rnd_t        r;
    t = {acc[63], acc[63:24]} + {40'd0, acc[23]};
    r.sat = 1'b0;
    r.q   = t[31:0];
    if (!t[40] && (t[39:31] != 9'h000)) begin
      r.sat = 1'b1;
      r.q   = 32'h7fff_ffff;
    end else if (t[40] && (t[39:31] != 9'h1ff)) begin
      r.sat = 1'b1;
      r.q   = 32'h8000_0000;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/stencil_weighted_sum_engine.sv =====
// Stencil weighted-sum engine. Command 0 loads one control component (Q16.16)
// into the control store. Commands 1 and 2 add a term: for each of n_eff
// components (element_length clamped to 1..MAX_COMPONENTS) one shared 32x32
// multiplier forms component times weight (Q8.24), and a 64-bit saturating
// adder folds it into that component's accumulator; derivative mode runs the
// multiplier twice per component (du, then dv). A term steps through ops
// operations, where ops is n_eff in value mode and 2*n_eff in derivative
// mode, all through the single multiplier fed from the one store read port;
// it then waits for the read/multiply/accumulate pipeline to drain, and
// command 1 returns to idle. A finish (command 2 or 3) then emits one
// rounded, saturated item per component, one per cycle while the output is
// taken, and clears the accumulators. Input is not taken while a term or an
// emission is in progress. The control store has no reset; a term must only
// read entries that were loaded.
`default_nettype none
module stencil_weighted_sum_engine
  import swe_pkg::*;
#(
  parameter int unsigned MAX_VERTICES   = MAX_VERTICES_DEF,
  parameter int unsigned MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o
);

  localparam int unsigned DEPTH = MAX_VERTICES * MAX_COMPONENTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned OPW   = $clog2(2 * MAX_COMPONENTS + 1);

  state_e           state_q, state_d;
  in_item_t         item_q, item_d;
  logic [OPW-1:0]   op_q, op_d;
  logic [3:0]       emit_k_q, emit_k_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             eval_mode_q;
  logic [4:0]       element_length_q;

  logic [4:0]       n_eff;
  logic [OPW-1:0]   ops_total;
  logic [3:0]       op_comp;
  logic             in_acc;
  logic             vtx_ok, in_vtx_ok, in_comp_ok;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [31:0]      ram_rdata;
  mac_tag_t         tag;
  logic             mac_busy, mac_clear, mac_ovf;
  logic [63:0]      acc_first, acc_second;
  rnd_t             rnd_first, rnd_second;
  logic             emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_mode_q      <= 1'b0;
      element_length_q <= 5'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_EVAL_MODE:      eval_mode_q      <= cfg_data_i[0];
        CFG_ELEMENT_LENGTH: element_length_q <= cfg_data_i;
      endcase
    end
  end

  assign n_eff = (element_length_q == 5'd0) ? 5'd1 :
                 (element_length_q > 5'(MAX_COMPONENTS)) ? 5'(MAX_COMPONENTS) :
                 element_length_q;
  assign ops_total = eval_mode_q ? OPW'({n_eff, 1'b0}) : OPW'(n_eff);
  assign op_comp   = eval_mode_q ? 4'(op_q >> 1) : 4'(op_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_vtx_ok  = 32'(in_item_i.vertex_index) < 32'(MAX_VERTICES);
  assign in_comp_ok = 32'(in_item_i.component) < 32'(MAX_COMPONENTS);
  assign vtx_ok     = in_vtx_ok;

  assign rnd_first  = round_q(acc_first);
  assign rnd_second = round_q(acc_second);
  assign emit_last  = (5'(emit_k_q) == (n_eff - 5'd1));

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    op_d        = op_q;
    emit_k_d    = emit_k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_addr    = AW'(32'(item_q.vertex_index) * 32'(MAX_COMPONENTS) + 32'(op_comp));
    tag         = '0;
    mac_clear   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_d   = in_item_i;
          op_d     = '0;
          emit_k_d = '0;
          unique case (in_item_i.command)
            CMD_LOAD: begin
              ram_we   = vtx_ok && in_comp_ok;
              ram_addr = AW'(32'(in_item_i.vertex_index) * 32'(MAX_COMPONENTS)
                             + 32'(in_item_i.component));
            end
            CMD_TERM, CMD_TERM_FINISH: begin
              if (vtx_ok) begin
                state_d = ST_TERM;
              end else if (in_item_i.command == CMD_TERM_FINISH) begin
                state_d = ST_EMIT;
              end
            end
            CMD_FINISH: state_d = ST_EMIT;
          endcase
        end
      end
      ST_TERM: begin
        tag.valid = 1'b1;
        tag.sel   = eval_mode_q && op_q[0];
        tag.comp  = op_comp;
        op_d      = op_q + OPW'(1);
        if (op_q == ops_total - OPW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_d = (item_q.command == CMD_TERM_FINISH) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!mac_busy && (!out_valid_q || out_ready_i)) begin
          out_valid_d         = 1'b1;
          out_d.out_component = emit_k_q;
          out_d.sum_first     = $signed(rnd_first.q);
          out_d.sum_second    = eval_mode_q ? $signed(rnd_second.q) : 32'sd0;
          out_d.saturated     = mac_ovf || rnd_first.sat || (eval_mode_q && rnd_second.sat);
          out_d.last          = emit_last;
          emit_k_d            = emit_k_q + 4'd1;
          if (emit_last) begin
            mac_clear = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      emit_k_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      emit_k_q    <= emit_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  swe_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_item_i.control_value),
    .rdata_o (ram_rdata)
  );

  swe_mac u_mac (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tag_i           (tag),
    .rdata_i         (ram_rdata),
    .weight_first_i  (item_q.weight_first),
    .weight_second_i (item_q.weight_second),
    .rd_comp_i       (emit_k_q),
    .clear_i         (mac_clear),
    .busy_o          (mac_busy),
    .acc_first_o     (acc_first),
    .acc_second_o    (acc_second),
    .overflow_o      (mac_ovf)
  );

endmodule
`default_nettype wire

// ===== design/swe_ram.sv =====
`default_nettype none
module swe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

// ===== design/swe_mac.sv =====
`default_nettype none
module swe_mac
  import swe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mac_tag_t           tag_i,
  input  wire logic [31:0]        rdata_i,
  input  wire logic signed [31:0] weight_first_i,
  input  wire logic signed [31:0] weight_second_i,
  input  wire logic [3:0]         rd_comp_i,
  input  wire logic               clear_i,
  output logic                    busy_o,
  output logic [63:0]             acc_first_o,
  output logic [63:0]             acc_second_o,
  output logic                    overflow_o
);

  mac_tag_t           tag1_q, tag2_q;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] cv, w;
  logic [63:0]        acc_first_q  [16];
  logic [63:0]        acc_second_q [16];
  logic               ovf_q;
  logic [3:0]         idx;
  logic [63:0]        acc_sel;
  logic [64:0]        sum;
  logic [63:0]        sum_sat;
  logic               sum_ovf;

  assign cv     = $signed(rdata_i);
  assign w      = tag1_q.sel ? weight_second_i : weight_first_i;
  assign prod_d = cv * w;

  assign idx          = tag2_q.valid ? tag2_q.comp : rd_comp_i;
  assign acc_first_o  = acc_first_q[idx];
  assign acc_second_o = acc_second_q[idx];
  assign acc_sel      = tag2_q.sel ? acc_second_o : acc_first_o;

  assign sum     = {acc_sel[63], acc_sel} + {prod_q[63], prod_q};
  assign sum_ovf = sum[64] != sum[63];
  assign sum_sat = sum_ovf ? (sum[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff)
                           : sum[63:0];

  assign busy_o     = tag1_q.valid || tag2_q.valid;
  assign overflow_o = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        acc_first_q[i]  <= '0;
        acc_second_q[i] <= '0;
      end
    end else if (clear_i) begin
      ovf_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        acc_first_q[i]  <= '0;
        acc_second_q[i] <= '0;
      end
    end else if (tag2_q.valid) begin
      if (sum_ovf) begin
        ovf_q <= 1'b1;
      end
      if (tag2_q.sel) begin
        acc_second_q[tag2_q.comp] <= sum_sat;
      end else begin
        acc_first_q[tag2_q.comp] <= sum_sat;
      end
    end
  end

endmodule
`default_nettype wire
